FILE: sv/banked_interrupt_claim_controller_core_assert.svh
// Assertion macros shared by the interrupt claim controller.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef BANKED_INTERRUPT_CLAIM_CONTROLLER_CORE_ASSERT_SVH
`define BANKED_INTERRUPT_CLAIM_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication.
`define BICC_ASSERT_SAME(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication.
`define BICC_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

FILE: sv/bicc_pkg.sv
package bicc_pkg;

	localparam int BANKS_DEF = 3;
	localparam int LINES_DEF = 32;
	localparam int HID_W_DEF = 8;

	localparam int OP_W   = 2;
	localparam int BANK_W = 2;
	localparam int LINE_W = 5;
	localparam int HID_W  = 8;
	localparam int ST_W   = 2;

	localparam logic [OP_W-1:0] OP_REGISTER = 2'd0;
	localparam logic [OP_W-1:0] OP_RAISE    = 2'd1;
	localparam logic [OP_W-1:0] OP_CLAIM    = 2'd2;

	localparam logic [ST_W-1:0] ST_OK       = 2'd0;
	localparam logic [ST_W-1:0] ST_BAD_BANK = 2'd1;
	localparam logic [ST_W-1:0] ST_NONE     = 2'd2;

	// One request travelling down the row of bank cells, with its result so far.
	typedef struct packed {
		logic              valid;
		logic [OP_W-1:0]   op;
		logic [BANK_W-1:0] bank;
		logic [LINE_W-1:0] line;
		logic [HID_W-1:0]  hid;
		logic [ST_W-1:0]   status;
		logic [HID_W-1:0]  res_hid;
		logic [BANK_W-1:0] res_bank;
		logic [LINE_W-1:0] res_line;
	} tok_t;

endpackage

FILE: sv/bicc_cell.sv
module bicc_cell import bicc_pkg::*; #(
	parameter int BANK_INDEX     = 0,
	parameter int LINES_PER_BANK = LINES_DEF,
	parameter int HANDLER_ID_WIDTH = HID_W_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  tok_t tok_in,
	output tok_t tok_out
);

	localparam int LW = (LINES_PER_BANK > 1) ? $clog2(LINES_PER_BANK) : 1;

	logic [LINES_PER_BANK-1:0]   pend_q;
	logic [LINES_PER_BANK-1:0]   reg_q;
	logic [HANDLER_ID_WIDTH-1:0] hid_q [LINES_PER_BANK];
	tok_t                        tok_q;

	logic [LINES_PER_BANK-1:0] ready;
	logic [LW-1:0]             sel;
	logic                      any;
	logic [LW-1:0]             lidx;
	logic                      hit;
	logic                      win;
	logic [15:0]               hid_wide;
	logic [15:0]               hid_rd;
	tok_t                      nxt;

	assign lidx     = tok_in.line[LW-1:0];
	// Banks that the bank field cannot address are never hit.
	assign hit      = tok_in.valid && (tok_in.status == ST_OK)
		&& (32'(tok_in.bank) == BANK_INDEX);
	assign hid_wide = 16'(tok_in.hid);
	assign hid_rd   = 16'(hid_q[sel]);

	// Lowest ready line wins.
	always_comb begin
		ready = reg_q & pend_q;
		sel   = '0;
		any   = 1'b0;
		for (int i = LINES_PER_BANK - 1; i >= 0; i--) begin
			if (ready[i]) begin
				sel = LW'(i);
				any = 1'b1;
			end
		end
	end

	// A claim still marked as unserved is taken by the first bank with a ready line.
	assign win = tok_in.valid && (tok_in.op == OP_CLAIM) && (tok_in.status == ST_NONE) && any;

	always_comb begin
		nxt = tok_in;
		if (win) begin
			nxt.status   = ST_OK;
			nxt.res_hid  = hid_rd[HID_W-1:0];
			nxt.res_bank = BANK_W'(BANK_INDEX);
			nxt.res_line = LINE_W'(sel);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			reg_q  <= '0;
		end else if (adv && tok_in.valid) begin
			unique case (tok_in.op)
				OP_REGISTER: if (hit) reg_q[lidx] <= 1'b1;
				OP_RAISE:    if (hit) pend_q[lidx] <= 1'b1;
				OP_CLAIM:    if (win) pend_q[sel] <= 1'b0;
				default:     ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv && hit && (tok_in.op == OP_REGISTER)) begin
			hid_q[lidx] <= hid_wide[HANDLER_ID_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (adv) begin
			tok_q <= nxt;
		end
	end

	assign tok_out = tok_q;

endmodule

FILE: sv/banked_interrupt_claim_controller_core.sv
// Banked interrupt claim controller.
// Requests arrive on the s_axis channel: tuser carries the operation (register,
// raise or claim) and tdata the bank, line and handler id. Every request gives
// exactly one response on the m_axis channel: tuser carries the status and
// tdata the claimed handler id, bank and line, all zero unless a claim succeeds.
// The request walks a row of BANKS cells, one cell per bank, and moves on by
// one cell whenever the row advances; each cell keeps the pending and
// registered bits and handler ids of its bank. A claim is served by the first
// cell with a registered, pending line. One request can be taken every cycle
// while the row is not stalled, since requests stay in order in every cell.
// The whole row advances only when the last cell's response is free or is
// being taken, so a stalled receiver stops s_axis_tready in the same cycle and
// nothing is lost. Reset clears all pending and registered bits and empties
// the row; handler ids are stored without reset and are only read for
// registered lines.
module banked_interrupt_claim_controller_core import bicc_pkg::*; #(
	parameter int BANKS            = BANKS_DEF,
	parameter int LINES_PER_BANK   = LINES_DEF,
	parameter int HANDLER_ID_WIDTH = HID_W_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // source_bank[1:0], source_line[6:2], handler_id[14:7]
	input  logic [1:0]  s_axis_tuser,  // operation[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // claimed_handler[7:0], claimed_bank[9:8], claimed_line[14:10]
	output logic [1:0]  m_axis_tuser   // status[1:0]
);

	`include "banked_interrupt_claim_controller_core_assert.svh"

	tok_t tok [BANKS+1];
	tok_t tok_head;
	logic adv;
	logic bad;

	assign adv           = !tok[BANKS].valid || m_axis_tready;
	assign s_axis_tready = adv;

	assign bad = (32'(s_axis_tdata[1:0]) >= BANKS)
		|| (32'(s_axis_tdata[6:2]) >= LINES_PER_BANK);

	always_comb begin
		tok_head          = '0;
		tok_head.valid    = s_axis_tvalid;
		tok_head.op       = s_axis_tuser;
		tok_head.bank     = s_axis_tdata[1:0];
		tok_head.line     = s_axis_tdata[6:2];
		tok_head.hid      = s_axis_tdata[14:7];
		// A claim starts as unserved and turns OK in the cell that serves it.
		if (s_axis_tuser == OP_CLAIM) begin
			tok_head.status = ST_NONE;
		end else if (((s_axis_tuser == OP_REGISTER) || (s_axis_tuser == OP_RAISE)) && bad) begin
			tok_head.status = ST_BAD_BANK;
		end else begin
			tok_head.status = ST_OK;
		end
	end

	assign tok[0] = tok_head;

	for (genvar g = 0; g < BANKS; g++) begin : g_cell
		bicc_cell #(
			.BANK_INDEX      (g),
			.LINES_PER_BANK  (LINES_PER_BANK),
			.HANDLER_ID_WIDTH(HANDLER_ID_WIDTH)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.tok_in (tok[g]),
			.tok_out(tok[g+1])
		);
	end

	assign m_axis_tvalid = tok[BANKS].valid;
	assign m_axis_tuser  = tok[BANKS].status;
	assign m_axis_tdata  = {1'b0, tok[BANKS].res_line, tok[BANKS].res_bank, tok[BANKS].res_hid};

	`BICC_ASSERT_SAME(a_fail_zero,
		m_axis_tvalid && (m_axis_tuser != ST_OK),
		m_axis_tdata == 16'h0000,
		"failed response carries a nonzero claim")
	`BICC_ASSERT_SAME(a_status_code,
		m_axis_tvalid,
		(m_axis_tuser == ST_OK) || (m_axis_tuser == ST_BAD_BANK) || (m_axis_tuser == ST_NONE),
		"response status is not a defined code")
	`BICC_ASSERT_NEXT(a_enter_row,
		s_axis_tvalid && s_axis_tready,
		tok[1].valid,
		"accepted request did not enter the first cell")

endmodule
